// ===== design/keypad_scan_debounce_number_entry_top_macros.svh =====
// Assertion macros used by the keypad scanner checker.
`ifndef KEYPAD_SCAN_DEBOUNCE_NUMBER_ENTRY_TOP_MACROS_SVH
`define KEYPAD_SCAN_DEBOUNCE_NUMBER_ENTRY_TOP_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define KSD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define KSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define KSD_ASSERT_RESET(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/kpd_pkg.sv =====
// Shared types and constants of the keypad scanner.
`default_nettype none
package kpd_pkg;

    typedef logic [3:0] scan_t;

    localparam int unsigned ROWS       = 4;
    localparam int unsigned COLS       = 3;
    localparam int unsigned COL_BITS   = ROWS * COLS;

    // Active-low column readings of one row
    localparam logic [2:0] COL_IDLE = 3'b111;
    localparam logic [2:0] COL_1    = 3'b011;
    localparam logic [2:0] COL_2    = 3'b101;
    localparam logic [2:0] COL_3    = 3'b110;

    // Scan codes beyond the keys
    localparam scan_t SCAN_NONE  = 4'd15;
    localparam scan_t SCAN_MULTI = 4'd14;
    localparam scan_t KEY_STAR   = 4'd10;
    localparam scan_t KEY_HASH   = 4'd11;
    localparam scan_t KEY_LAST_DIGIT_RAW = 4'd11;  // raw position of digit 0
    localparam scan_t KEY_HASH_RAW       = 4'd12;  // raw position of '#'
    localparam scan_t DIGIT_LIMIT        = 4'd10;
    localparam logic [3:0] DIGITS_SAT    = 4'd15;

    // Configuration register indexes
    localparam logic CFG_DEBOUNCE = 1'b0;
    localparam logic CFG_REQUIRED = 1'b1;

    localparam logic [7:0] DEBOUNCE_RESET = 8'd30;
    localparam logic [3:0] REQUIRED_RESET = 4'd0;

endpackage
`default_nettype wire

// ===== design/kpd_scan_decode.sv =====
// Decoder from four row readings to one scan code.
`default_nettype none
module kpd_scan_decode (
    input  wire logic [kpd_pkg::COL_BITS-1:0] columns,
    output kpd_pkg::scan_t                    scan_code
);
    import kpd_pkg::*;

    logic [1:0] pos;
    logic       hit;
    logic       found;
    logic       stop;
    scan_t      raw;
    logic [2:0] col;

    always_comb begin
        scan_code = SCAN_NONE;
        found     = 1'b0;
        stop      = 1'b0;
        raw       = '0;
        pos       = '0;
        hit       = 1'b0;
        col       = '0;
        // walk rows in order; a bad pattern or a second row ends the walk
        for (int r = 0; r < ROWS; r++) begin
            col = columns[r*COLS +: COLS];
            hit = 1'b1;
            case (col)
                COL_IDLE: hit = 1'b0;
                COL_1:    pos = 2'd1;
                COL_2:    pos = 2'd2;
                COL_3:    pos = 2'd3;
                default: begin
                    hit = 1'b0;
                    if (!stop) begin
                        scan_code = SCAN_NONE;
                        stop      = 1'b1;
                    end
                end
            endcase
            if (hit && !stop) begin
                if (found) begin
                    scan_code = SCAN_MULTI;
                    stop      = 1'b1;
                end else begin
                    found = 1'b1;
                    raw   = scan_t'({2'b00, pos}) + scan_t'(3 * r);
                end
            end
        end
        if (!stop && found) begin
            if (raw == KEY_LAST_DIGIT_RAW) begin
                scan_code = '0;
            end else if (raw == KEY_HASH_RAW) begin
                scan_code = KEY_HASH;
            end else begin
                scan_code = raw;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/keypad_scan_debounce_number_entry_top.sv =====
// Top level: 4x3 keypad scan debounce and decimal number entry.
// Flow: an accepted request is captured in the input register and processed from there; its result
// (if any) is loaded into the result register, from which it can be taken.
// Throughput: one scan request per cycle unless the result stage stalls; input and result register stages.
// Reset (aresetn low, synchronous): both stages empty, debounce 30, required digits 0,
// press phase, count 0, previous scan none, number and digit count cleared.
`default_nettype none
module keypad_scan_debounce_number_entry_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // scan request: [2:0] row0_columns, [5:3] row1_columns,
    // [8:6] row2_columns, [11:9] row3_columns, [15:12] zero
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,
    // result: [3:0] key_code, [19:4] number_value, [23:20] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    // end of number: number_done
    output logic             m_tlast,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_wdata
);
    import kpd_pkg::*;

    // configuration
    logic [7:0]  debounce_reg;
    logic [3:0]  required_reg;

    // input stage
    logic                in_valid_reg;
    logic [COL_BITS-1:0] in_cols_reg;

    // scan state
    logic        release_reg,  release_next;
    logic [7:0]  count_reg,    count_next;
    scan_t       prev_reg,     prev_next;
    scan_t       held_reg,     held_next;
    logic [15:0] acc_reg,      acc_next;   // low 16 bits suffice for the reported value
    logic [3:0]  digits_reg,   digits_next;

    // result stage
    logic        out_valid_reg, out_valid_next;
    scan_t       out_key_reg;
    logic [15:0] out_value_reg, out_value_next;
    logic        out_done_reg,  out_done_next;

    scan_t       scan;
    logic [7:0]  limit;
    logic [7:0]  count_inc;
    logic [15:0] acc_step;
    logic        fire;
    logic        advance;
    logic        process;

    kpd_scan_decode u_decode (
        .columns   (in_cols_reg),
        .scan_code (scan)
    );

    // result stage frees up when empty or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign process  = in_valid_reg && advance;

    assign limit     = (debounce_reg == 8'd0) ? 8'd1 : debounce_reg;
    assign count_inc = count_reg + 8'd1;
    // value*10 + digit as two shifted adds
    assign acc_step  = {acc_reg[12:0], 3'b000} + {acc_reg[14:0], 1'b0}
                     + {12'd0, held_reg};

    always_comb begin
        release_next   = release_reg;
        count_next     = count_reg;
        prev_next      = prev_reg;
        held_next      = held_reg;
        acc_next       = acc_reg;
        digits_next    = digits_reg;
        fire           = 1'b0;
        out_value_next = out_value_reg;
        out_done_next  = out_done_reg;

        if (!release_reg) begin
            // press phase: count repeats of one valid key
            if (scan <= KEY_HASH && scan == prev_reg) begin
                count_next = count_inc;
            end else begin
                count_next = '0;
            end
            prev_next = scan;
            if (count_next >= limit) begin
                held_next    = scan;
                release_next = 1'b1;
                count_next   = '0;
            end
        end else begin
            // release phase: count consecutive empty scans
            if (scan == SCAN_NONE) begin
                count_next = count_inc;
            end else begin
                count_next = '0;
            end
            if (count_next >= limit) begin
                fire         = 1'b1;
                release_next = 1'b0;
                count_next   = '0;
                prev_next    = SCAN_NONE;
                if (held_reg == KEY_HASH) begin
                    out_done_next = 1'b1;
                end else begin
                    if (held_reg < DIGIT_LIMIT) begin
                        acc_next = acc_step;
                        if (digits_reg < DIGITS_SAT) begin
                            digits_next = digits_reg + 4'd1;
                        end
                    end
                    out_done_next = (required_reg != 4'd0) && (digits_next >= required_reg);
                end
                out_value_next = acc_next;
                // clear the number once it is complete
                if (out_done_next) begin
                    acc_next    = '0;
                    digits_next = '0;
                end
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = process && fire;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg  <= DEBOUNCE_RESET;
            required_reg  <= REQUIRED_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            release_reg   <= 1'b0;
            count_reg     <= '0;
            prev_reg      <= SCAN_NONE;
            held_reg      <= '0;
            acc_reg       <= '0;
            digits_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_DEBOUNCE: debounce_reg <= cfg_wdata;
                    CFG_REQUIRED: required_reg <= cfg_wdata[3:0];
                    default:      debounce_reg <= debounce_reg;
                endcase
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (process) begin
                release_reg <= release_next;
                count_reg   <= count_next;
                prev_reg    <= prev_next;
                held_reg    <= held_next;
                acc_reg     <= acc_next;
                digits_reg  <= digits_next;
            end
        end
    end

    // payload registers: capture the request, load the result on a report
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cols_reg <= s_tdata[COL_BITS-1:0];
        end
        if (process && fire) begin
            out_key_reg   <= held_reg;
            out_value_reg <= out_value_next;
            out_done_reg  <= out_done_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_value_reg, out_key_reg};
    assign m_tlast  = out_done_reg;

endmodule
`default_nettype wire

// ===== design/kpd_checker.sv =====
// Port-level checker for the keypad scanner, bound to the top level.
`default_nettype none
`include "keypad_scan_debounce_number_entry_top_macros.svh"
module kpd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);
    import kpd_pkg::*;

    // a stalled result holds its payload
    `KSD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // only real key codes are reported
    `KSD_ASSERT_IMPL(a_key_range, m_tvalid, m_tdata[3:0] <= KEY_HASH, "reported key code out of range")

    // a hash key always completes the number
    `KSD_ASSERT_IMPL(a_hash_done, m_tvalid && m_tdata[3:0] == KEY_HASH, m_tlast, "hash did not complete number")

    // reset leaves no result pending
    `KSD_ASSERT_RESET(a_reset_empty, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind keypad_scan_debounce_number_entry_top kpd_checker u_kpd_checker (.*);
`default_nettype wire
